// ----- hdl/slt_pkg.sv -----
// ----------------------------------------------------------------------------
// slt_pkg: shared definitions for the slot tracker
// Request codes, the token that travels down the cell chain, and default sizes.
// ----------------------------------------------------------------------------
package slt_pkg;

	localparam int SLOT_COUNT_DEF = 64;
	localparam int TAG_WIDTH_DEF  = 64;

	// Widths of the request and result fields.
	localparam int TAG_IN_W = 64;
	localparam int SLOT_W   = 7;

	// Slot number that means "none" or "full".
	localparam logic [SLOT_W-1:0] NO_SLOT = 7'd64;

	typedef enum logic [1:0] {
		OP_TRACK      = 2'd0,
		OP_REMOVE     = 2'd1,
		OP_ITER_CLEAR = 2'd2,
		OP_FIND       = 2'd3
	} slt_op_t;

	// Control part of a request as it passes from cell to cell.
	typedef struct packed {
		logic              valid;
		slt_op_t           op;
		logic [SLOT_W-1:0] idx;
		logic              done;
		logic [SLOT_W-1:0] slot;
		logic              ok;
	} slt_token_t;

endpackage

// ----- hdl/slot_tracker_bitmap_allocator.sv -----
// ----------------------------------------------------------------------------
// slot_tracker_bitmap_allocator: tag tracker with a free bitmap
// Chain of slot cells searched from the highest slot down.
// ----------------------------------------------------------------------------
// Usage: a request (req_type, tag_value, slot_index) is taken on the input
// channel when in_valid and in_ready are both high. Track claims the highest
// free slot, remove frees a slot whose tag matches, iterate-and-clear frees
// the highest occupied slot and find returns the highest occupied slot with a
// matching tag. Every request gives one result (slot_number, success); a
// slot_number of 64 means no slot.
// The request walks down the cell chain one slot per cycle, from the highest
// slot to slot 0, while the chain is not held. One request is in the chain at
// a time; the next one is taken in the cycle after the previous one leaves
// slot 0. The result sits in an output register, so a new request can be
// taken while a result waits; if the receiver stalls, the chain holds at
// slot 0 until the waiting result is taken.
// After reset every slot is free and all stored tags are zero; no clearing
// pass is needed.
// ----------------------------------------------------------------------------
module slot_tracker_bitmap_allocator #(
	parameter int SLOT_COUNT = slt_pkg::SLOT_COUNT_DEF,
	parameter int TAG_WIDTH  = slt_pkg::TAG_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      req_type,
	input  logic [slt_pkg::TAG_IN_W-1:0]    tag_value,
	input  logic [slt_pkg::SLOT_W-1:0]      slot_index,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [slt_pkg::SLOT_W-1:0]      slot_number,
	output logic                            success
);

	slt_pkg::slt_token_t  tok_link [SLOT_COUNT+1];
	logic [TAG_WIDTH-1:0] tag_link [SLOT_COUNT+1];

	logic busy_q;
	logic out_valid_q;
	logic [slt_pkg::SLOT_W-1:0] slot_q;
	logic success_q;
	logic accept;
	logic advance;
	logic leave;

	assign in_ready = !busy_q;
	assign accept   = in_valid && in_ready;

	// Only a request in the bottom cell can be blocked by a waiting result; the whole chain then holds.
	assign advance = !(tok_link[0].valid && out_valid_q && !out_ready);
	assign leave   = tok_link[0].valid && advance;

	always_comb begin
		tok_link[SLOT_COUNT].valid = accept;
		tok_link[SLOT_COUNT].op    = slt_pkg::slt_op_t'(req_type);
		tok_link[SLOT_COUNT].idx   = slot_index;
		tok_link[SLOT_COUNT].done  = 1'b0;
		tok_link[SLOT_COUNT].slot  = slt_pkg::NO_SLOT;
		tok_link[SLOT_COUNT].ok    = 1'b0;
	end
	assign tag_link[SLOT_COUNT] = tag_value[TAG_WIDTH-1:0];

	for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
		slt_cell #(
			.TAG_WIDTH  (TAG_WIDTH),
			.CELL_INDEX (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.tok_in  (tok_link[i+1]),
			.tag_in  (tag_link[i+1]),
			.tok_out (tok_link[i]),
			.tag_out (tag_link[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (leave) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (leave) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (leave) begin
			slot_q    <= tok_link[0].slot;
			success_q <= tok_link[0].ok;
		end
	end

	assign out_valid   = out_valid_q;
	assign slot_number = slot_q;
	assign success     = success_q;

endmodule

// ----- hdl/slt_cell.sv -----
// ----------------------------------------------------------------------------
// slt_cell: one slot of the tracker
// Holds the free bit and stored tag of one slot, acts on the request passing
// through it and hands the updated request to the next lower slot.
// ----------------------------------------------------------------------------
module slt_cell #(
	parameter int TAG_WIDTH  = slt_pkg::TAG_WIDTH_DEF,
	parameter int CELL_INDEX = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  slt_pkg::slt_token_t    tok_in,
	input  logic [TAG_WIDTH-1:0]   tag_in,
	output slt_pkg::slt_token_t    tok_out,
	output logic [TAG_WIDTH-1:0]   tag_out
);

	localparam logic [slt_pkg::SLOT_W-1:0] MY_SLOT = slt_pkg::SLOT_W'(CELL_INDEX);

	slt_pkg::slt_token_t  token_q;
	logic [TAG_WIDTH-1:0] tag_q;
	logic                 free_q;
	logic [TAG_WIDTH-1:0] stored_q;

	logic tag_hit;
	logic claim;
	logic release_slot;
	logic select;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_q <= '0;
		end else if (advance) begin
			token_q <= tok_in;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tag_q <= tag_in;
		end
	end

	always_comb begin
		tag_hit      = (stored_q == tag_q);
		claim        = 1'b0;
		release_slot = 1'b0;
		select       = 1'b0;
		case (token_q.op)
			slt_pkg::OP_TRACK: begin
				claim  = !token_q.done && free_q;
				select = claim;
			end
			slt_pkg::OP_REMOVE: begin
				// A free slot still compares its stale tag.
				release_slot = (token_q.idx == MY_SLOT) && tag_hit;
			end
			slt_pkg::OP_ITER_CLEAR: begin
				release_slot = !token_q.done && !free_q;
				select       = release_slot;
			end
			default: begin
				select = !token_q.done && !free_q && tag_hit;
			end
		endcase
	end

	always_comb begin
		tok_out = token_q;
		if (select) begin
			tok_out.done = 1'b1;
			tok_out.slot = MY_SLOT;
		end
		if (token_q.op == slt_pkg::OP_REMOVE && release_slot) begin
			tok_out.ok = 1'b1;
		end
	end

	assign tag_out = tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q   <= 1'b1;
			stored_q <= '0;
		end else if (advance && token_q.valid) begin
			if (claim) begin
				free_q   <= 1'b0;
				stored_q <= tag_q;
			end else if (release_slot) begin
				free_q <= 1'b1;
			end
		end
	end

endmodule

// ----- hdl/slt_checker.sv -----
// ----------------------------------------------------------------------------
// slt_checker: port-level checks for the slot tracker
// Watches the top-level channels and flags results that cannot occur.
// ----------------------------------------------------------------------------
module slt_checker #(
	parameter int SLOT_COUNT = slt_pkg::SLOT_COUNT_DEF
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [slt_pkg::SLOT_W-1:0] slot_number,
	input logic                       success
);

	// A stalled result keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(slot_number) && $stable(success))
		else $error("result changed while stalled");

	// Only one request is in flight; ready drops once one is taken.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request taken while one is in flight");

	// A successful remove never reports a slot number.
	a_success_no_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && success |-> slot_number == slt_pkg::NO_SLOT)
		else $error("success reported with a slot number");

	// Reported slots lie inside the table.
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && slot_number != slt_pkg::NO_SLOT |->
			slot_number < slt_pkg::SLOT_W'(SLOT_COUNT))
		else $error("slot number out of range");

endmodule

bind slot_tracker_bitmap_allocator slt_checker #(.SLOT_COUNT(SLOT_COUNT)) u_slt_checker (.*);

// ----- bench/tb_slot_tracker_bitmap_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_slot_tracker_bitmap_allocator: self-checking bench for the slot tracker
// Drives track, remove, iterate-and-clear and find requests through the
// valid/ready input and keeps its own copy of the free map and tag store.
// Every result is checked against that copy in request order. The run has a
// short directed part, then random phases that fill, empty and mix the table.
// Both sides idle at random, and the receiver holds off once for a long spell.
// ----------------------------------------------------------------------------
module tb_slot_tracker_bitmap_allocator;
	import slt_pkg::*;

	localparam int SLOTS       = SLOT_COUNT_DEF;
	localparam int ITEMS       = 1900;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 3 * SLOT_COUNT_DEF;

	localparam int MODE_FILL  = 0;
	localparam int MODE_MIXED = 1;
	localparam int MODE_EMPTY = 2;

	typedef struct {
		slt_op_t           op;
		logic [SLOT_W-1:0] slot;
		logic              ok;
	} slot_answer_t;

	// Shadow of the tracker: free map, tag store and the answers still owed.
	class tracker_shadow;
		logic [SLOTS-1:0]    free_map;
		logic [TAG_IN_W-1:0] tag_store [SLOTS];
		slot_answer_t        answers_due [$];
		int                  errors;

		function new();
			free_map = '1;
			foreach (tag_store[i])
				tag_store[i] = '0;
			errors = 0;
		endfunction

		function int pending();
			return answers_due.size();
		endfunction

		function logic [SLOT_W-1:0] highest_set(logic [SLOTS-1:0] bits);
			for (int b = SLOTS - 1; b >= 0; b--)
				if (bits[b])
					return SLOT_W'(b);
			return NO_SLOT;
		endfunction

		// The log is capped so that a badly broken block cannot flood it.
		task report_mismatch(string msg);
			if (errors < 100)
				$display("%0t ns: mismatch: %s", $time, msg);
			errors++;
		endtask

		task note_request(slt_op_t op, logic [TAG_IN_W-1:0] tag, logic [SLOT_W-1:0] idx);
			slot_answer_t     ans;
			logic [SLOTS-1:0] used;
			ans.op = op;
			ans.slot = NO_SLOT;
			ans.ok = 1'b0;
			used = ~free_map;
			case (op)
			OP_TRACK: begin
				ans.slot = highest_set(free_map);
				if (ans.slot != NO_SLOT) begin
					free_map[ans.slot[5:0]] = 1'b0;
					tag_store[ans.slot[5:0]] = tag;
				end
			end
			OP_REMOVE: begin
				// A free slot still holds its old tag, and a match frees it again.
				if (idx < SLOTS && tag_store[idx[5:0]] == tag) begin
					free_map[idx[5:0]] = 1'b1;
					ans.ok = 1'b1;
				end
			end
			OP_ITER_CLEAR: begin
				ans.slot = highest_set(used);
				if (ans.slot != NO_SLOT)
					free_map[ans.slot[5:0]] = 1'b1;
			end
			default: begin
				for (int s = SLOTS - 1; s >= 0; s--) begin
					if (used[s] && tag_store[s] == tag && ans.slot == NO_SLOT)
						ans.slot = SLOT_W'(s);
				end
			end
			endcase
			answers_due.push_back(ans);
		endtask

		task check_result(logic [SLOT_W-1:0] slot, logic ok);
			slot_answer_t ans;
			if (answers_due.size() == 0) begin
				report_mismatch($sformatf("result slot %0d success %0b with no request owed",
					slot, ok));
				return;
			end
			ans = answers_due.pop_front();
			if (slot !== ans.slot)
				report_mismatch($sformatf("%s: slot_number %0d, expected %0d",
					ans.op.name(), slot, ans.slot));
			if (ok !== ans.ok)
				report_mismatch($sformatf("%s: success %0b, expected %0b",
					ans.op.name(), ok, ans.ok));
		endtask

		task close_out();
			while (answers_due.size() != 0) begin
				report_mismatch($sformatf("%s: no result arrived",
					answers_due[0].op.name()));
				void'(answers_due.pop_front());
			end
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [1:0]          req_type;
	logic [TAG_IN_W-1:0] tag_value;
	logic [SLOT_W-1:0]   slot_index;
	logic                out_valid;
	logic                out_ready;
	logic [SLOT_W-1:0]   slot_number;
	logic                success;

	tracker_shadow       sb = new();
	logic [TAG_IN_W-1:0] tag_pool [8];
	bit                  calm = 1'b0;
	bit                  long_hold = 1'b0;

	slot_tracker_bitmap_allocator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.tag_value   (tag_value),
		.slot_index  (slot_index),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.slot_number (slot_number),
		.success     (success)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#20ms;
		$display("simulation failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
			sb.check_result(slot_number, success);
	end

	// Receiver: random stalls, none while calm, and one long hold-off on demand.
	initial begin
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				long_hold = 1'b0;
				out_ready <= 1'b1;
			end else if (calm || $urandom_range(0, 7) != 0) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				repeat ($urandom_range(0, 16)) @(posedge clk);
			end
		end
	end

	task automatic send_request(input slt_op_t op, input logic [TAG_IN_W-1:0] tag,
		input logic [SLOT_W-1:0] idx);
		in_valid <= 1'b1;
		req_type <= op;
		tag_value <= tag;
		slot_index <= idx;
		@(posedge clk);
		while (in_ready !== 1'b1)
			@(posedge clk);
		sb.note_request(op, tag, idx);
	endtask

	task automatic idle_sender(input int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic [TAG_IN_W-1:0] pick_tag();
		case ($urandom_range(0, 9))
		0: return '0;
		1: return '1;
		2, 3, 4, 5: return tag_pool[$urandom_range(0, 7)];
		default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic int some_used_slot();
		int start;
		start = $urandom_range(0, SLOTS - 1);
		for (int k = 0; k < SLOTS; k++)
			if (!sb.free_map[(start + k) % SLOTS])
				return (start + k) % SLOTS;
		return -1;
	endfunction

	task automatic pick_request(input int mode, output slt_op_t op,
		output logic [TAG_IN_W-1:0] tag, output logic [SLOT_W-1:0] idx);
		int r;
		int s;
		r = $urandom_range(0, 99);
		case (mode)
		MODE_FILL:  op = r < 75 ? OP_TRACK : r < 85 ? OP_FIND : r < 95 ? OP_REMOVE : OP_ITER_CLEAR;
		MODE_EMPTY: op = r < 10 ? OP_TRACK : r < 55 ? OP_REMOVE : r < 85 ? OP_ITER_CLEAR : OP_FIND;
		default:    op = slt_op_t'(r % 4);
		endcase
		tag = pick_tag();
		idx = SLOT_W'($urandom_range(0, 127));
		if (op == OP_REMOVE) begin
			r = $urandom_range(0, 9);
			s = some_used_slot();
			if (r < 7 && s >= 0) begin
				idx = SLOT_W'(s);
				tag = sb.tag_store[s];
			end else if (r == 7) begin
				idx = SLOT_W'($urandom_range(0, SLOTS - 1));
				tag = sb.tag_store[idx[5:0]];
			end else if (r == 8) begin
				idx = SLOT_W'($urandom_range(SLOTS, 127));
			end else begin
				idx = SLOT_W'($urandom_range(0, SLOTS - 1));
			end
		end else if (op == OP_FIND && $urandom_range(0, 9) < 6) begin
			tag = sb.tag_store[$urandom_range(0, SLOTS - 1)];
		end
	endtask

	initial begin
		int               sent;
		int               mode;
		int               span;
		slt_op_t          op;
		logic [TAG_IN_W-1:0] tag;
		logic [SLOT_W-1:0]   idx;

		arst_n <= 1'b0;
		in_valid <= 1'b0;
		req_type <= OP_TRACK;
		tag_value <= '0;
		slot_index <= '0;
		foreach (tag_pool[i])
			tag_pool[i] = {$urandom, $urandom};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table: nothing to find or clear, and the zeroed store matches tag 0.
		send_request(OP_FIND, '0, 7'd0);
		send_request(OP_ITER_CLEAR, '1, 7'd5);
		send_request(OP_REMOVE, '0, 7'd0);
		send_request(OP_REMOVE, '0, 7'd127);
		send_request(OP_REMOVE, '0, 7'd64);
		send_request(OP_TRACK, '1, 7'd127);
		send_request(OP_TRACK, '0, 7'd0);
		send_request(OP_TRACK, 64'h5555_5555_5555_5555, 7'd63);
		send_request(OP_TRACK, 64'h5555_5555_5555_5555, 7'd1);
		send_request(OP_FIND, 64'h5555_5555_5555_5555, 7'd0);
		send_request(OP_FIND, '1, 7'd100);
		send_request(OP_FIND, 64'hAAAA_AAAA_AAAA_AAAA, 7'd0);
		send_request(OP_REMOVE, 64'hAAAA_AAAA_AAAA_AAAA, 7'd63);
		send_request(OP_REMOVE, '1, 7'd63);
		send_request(OP_REMOVE, '1, 7'd63);
		send_request(OP_FIND, '1, 7'd0);
		send_request(OP_TRACK, 64'h8000_0000_0000_0001, 7'd0);
		repeat (5)
			send_request(OP_ITER_CLEAR, '0, 7'd0);
		send_request(OP_FIND, 64'h8000_0000_0000_0001, 7'd0);
		send_request(OP_REMOVE, 64'h8000_0000_0000_0001, 7'd63);
		wait_for_results();
		sent = 24;

		// The receiver stops for a long spell while requests keep coming.
		long_hold = 1'b1;
		for (int i = 0; i < 8; i++) begin
			pick_request(MODE_FILL, op, tag, idx);
			send_request(op, tag, idx);
		end
		sent += 8;
		wait_for_results();

		while (sent < ITEMS) begin
			mode = $urandom_range(MODE_FILL, MODE_EMPTY);
			span = $urandom_range(20, 90);
			calm = sent > ITEMS - 300 || $urandom_range(0, 4) == 0;
			for (int i = 0; i < span && sent < ITEMS; i++) begin
				pick_request(mode, op, tag, idx);
				send_request(op, tag, idx);
				sent++;
				if (!calm && $urandom_range(0, 5) == 0)
					idle_sender($urandom_range(1, 17));
			end
			if (!calm && $urandom_range(0, 3) == 0)
				wait_for_results();
		end

		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		sb.close_out();
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
